### hw/rtl/qbf_pkg.sv
// Shared types and constants for the quadratic curve flattener.
// Used by qbf_ctrl, qbf_lane and the top level; no dependencies.
package qbf_pkg;

  localparam int STEP_BITS = 16;
  localparam int T_BITS    = 17;
  localparam int W_SHIFT   = 32;
  localparam int D1_SHIFT  = 17;

  localparam logic [STEP_BITS-1:0] STEP_MIN   = 16'd1041;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd1311;

  typedef enum logic [1:0] {
    MOP_D1   = 2'd0,
    MOP_D2   = 2'd1,
    MOP_PROD = 2'd2
  } mop_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic mul;
    mop_t mop;
    logic save_p1;
    logic init;
    logic out_load;
    logic out_end;
  } qbf_cmd_t;

endpackage

### hw/rtl/qbf_lane.sv
// One coordinate lane: difference terms, shared step multiplier and the
// forward-difference accumulators that produce the rounded curve samples.
// Depends on qbf_pkg.
module qbf_lane #(
  parameter int CW = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qbf_pkg::qbf_cmd_t                    cmd,
  input  logic [qbf_pkg::STEP_BITS-1:0]        h,
  input  logic                                 new_path,
  input  logic signed [CW-1:0]                 start_c,
  input  logic signed [CW-1:0]                 ctrl_c,
  input  logic signed [CW-1:0]                 end_c,
  output logic signed [CW-1:0]                 point
);
  import qbf_pkg::*;

  localparam int DW1  = CW + 1;
  localparam int DW2  = CW + 2;
  localparam int MOPW = CW + 18;
  localparam int PRW  = MOPW + STEP_BITS + 1;
  localparam int AW   = CW + 37;

  logic signed [CW-1:0]   s;
  logic signed [CW-1:0]   c;
  logic signed [CW-1:0]   e;
  logic signed [DW1-1:0]  d1;
  logic signed [DW2-1:0]  d2;
  logic signed [PRW-1:0]  prod;
  logic signed [PRW-1:0]  p1;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   dlt;
  logic signed [AW-1:0]   dd;
  logic signed [MOPW-1:0] op;
  logic signed [STEP_BITS:0] hs;
  logic signed [AW-1:0]   rnd;

  assign hs  = {1'b0, h};
  assign rnd = acc + (AW'(1) <<< (W_SHIFT - 1));

  always_comb begin
    case (cmd.mop)
      MOP_D1:   op = MOPW'(d1);
      MOP_D2:   op = MOPW'(d2);
      MOP_PROD: op = prod[MOPW-1:0];
      default:  op = MOPW'(d1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e <= '0;
    end else if (cmd.load) begin
      e <= end_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s <= new_path ? start_c : e;
      c <= ctrl_c;
    end
    if (cmd.diff) begin
      d1 <= DW1'(c) - DW1'(s);
      d2 <= DW2'(s) + DW2'(e) - (DW2'(c) <<< 1);
    end
    if (cmd.mul) begin
      prod <= PRW'(op) * PRW'(hs);
    end
    if (cmd.save_p1) begin
      p1 <= prod;
    end
    if (cmd.init) begin
      acc <= AW'(s) <<< W_SHIFT;
      dlt <= (AW'(p1) <<< D1_SHIFT) + AW'(prod);
      dd  <= AW'(prod) <<< 1;
    end else if (cmd.out_load && !cmd.out_end) begin
      acc <= acc + dlt;
      dlt <= dlt + dd;
    end
    if (cmd.out_load) begin
      point <= cmd.out_end ? e : rnd[W_SHIFT+CW-1:W_SHIFT];
    end
  end

endmodule

### hw/rtl/qbf_ctrl.sv
// Sequencer for the flattener: input handshake, setup steps, parameter
// counter, step register and output valid. Depends on qbf_pkg.
module qbf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          last,
  input  logic                          step_size_we,
  input  logic [qbf_pkg::STEP_BITS-1:0] step_size,
  output qbf_pkg::qbf_cmd_t             cmd,
  output logic [qbf_pkg::STEP_BITS-1:0] h
);
  import qbf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIFF = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_MUL3 = 7'b0010000,
    S_INIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step;
  logic [T_BITS-1:0]    t;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul    = 1'b1;
        cmd.mop    = MOP_D1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul     = 1'b1;
        cmd.mop     = MOP_D2;
        cmd.save_p1 = 1'b1;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul    = 1'b1;
        cmd.mop    = MOP_PROD;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_end  = t[T_BITS-1];
          if (t[T_BITS-1]) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_RESET;
      out_valid <= 1'b0;
      t         <= '0;
    end else begin
      state <= state_next;
      if (step_size_we) begin
        step <= step_size;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        t <= '0;
      end else if (cmd.out_load && !cmd.out_end) begin
        t <= t + {1'b0, h};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h <= (step < STEP_MIN) ? STEP_MIN : step;
    end
    if (cmd.out_load) begin
      last <= cmd.out_end;
    end
  end

endmodule

### hw/rtl/quadratic_bezier_flattener_unit.sv
// Quadratic curve flattener top level: controller plus one lane per axis.
// Depends on qbf_pkg, qbf_ctrl and qbf_lane.
//
// Input channel (in_valid/in_stall) carries one curve segment: control and
// end point, and a start point taken only when new_path is 1; otherwise the
// segment starts at the previous segment's end. Output channel
// (out_valid/out_stall) carries the sample points in Q16.16, one per
// transfer, then the exact end point with last set.
// A segment with step h gives N = ceil(65536/h) samples plus the end point.
// After the input transfer come the setup steps (differences, three passes
// through the step multiplier of each lane, accumulator init); then the
// forward-difference adders give one point per cycle while the output
// is not stalled. in_stall is high from the input transfer until the end
// point sits in the output register; a stalled output holds its point and
// pauses the lanes. The user must write step_size through step_size_we
// only while idle; the block does not enforce this. Values below 1041 act
// as 1041. Reset sets step 1311 and the chained start point to (0,0).
module quadratic_bezier_flattener_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_size_we,
  input  logic [qbf_pkg::STEP_BITS-1:0] step_size,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          new_path,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic                          last
);
  import qbf_pkg::*;

  qbf_cmd_t             cmd;
  logic [STEP_BITS-1:0] h;

  qbf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .last         (last),
    .step_size_we (step_size_we),
    .step_size    (step_size),
    .cmd          (cmd),
    .h            (h)
  );

  qbf_lane #(.CW(COORD_WIDTH)) u_lane_x (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .h        (h),
    .new_path (new_path),
    .start_c  (start_x),
    .ctrl_c   (ctrl_x),
    .end_c    (end_x),
    .point    (point_x)
  );

  qbf_lane #(.CW(COORD_WIDTH)) u_lane_y (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .h        (h),
    .new_path (new_path),
    .start_c  (start_y),
    .ctrl_c   (ctrl_y),
    .end_c    (end_y),
    .point    (point_y)
  );

endmodule

### sim/quadratic_bezier_flattener_unit_tb.sv
// Testbench for quadratic_bezier_flattener_unit: directed curve segments, then random
// segments under several step sizes and idle patterns, each point checked in order.
// Depends on qbf_pkg and the quadratic_bezier_flattener_unit RTL.
module quadratic_bezier_flattener_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int SEGS_PER_STEP = 18;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;

  typedef struct packed {
    logic        np;
    logic [31:0] sx, sy, cx, cy, ex, ey;
  } seg_t;

  typedef struct packed {
    logic [31:0] px, py;
    logic        lst;
  } point_t;

  typedef struct packed {
    logic        set_step;
    logic [15:0] step;
    logic        typed;
    logic [31:0] fx, fy;
    seg_t        seg;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic step_size_we = 1'b0;
  logic [qbf_pkg::STEP_BITS-1:0] step_size = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic new_path = 1'b0;
  logic signed [31:0] start_x = '0, start_y = '0;
  logic signed [31:0] ctrl_x = '0, ctrl_y = '0;
  logic signed [31:0] end_x = '0, end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] point_x, point_y;
  logic last;

  point_t pending_pts[$];
  logic [15:0] cur_step = qbf_pkg::STEP_RESET;
  logic [31:0] path_x = '0, path_y = '0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  int in_idle_by_phase [4] = '{0, 76, 0, 14};
  int out_stall_by_phase [4] = '{0, 0, 76, 14};

  dir_row_t dir_rows [19] = '{
    '{1'b0, 16'd0, 1'b1, 32'h0, 32'h0,
      '{1'b0, PMAX, PMIN, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000}},
    '{1'b0, 16'd0, 1'b1, PMAX, PMAX, '{1'b1, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}},
    '{1'b0, 16'd0, 1'b1, PMIN, PMIN, '{1'b1, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN}},
    '{1'b0, 16'd0, 1'b1, PMAX, PMIN, '{1'b1, PMAX, PMIN, PMIN, PMAX, PMAX, PMIN}},
    '{1'b0, 16'd0, 1'b1, PMIN, PMAX, '{1'b1, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX}},
    '{1'b0, 16'd0, 1'b1, PMIN, PMAX, '{1'b0, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX}},
    '{1'b0, 16'd0, 1'b1, 32'h0, 32'h0, '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{1'b1, 16'd0, 1'b1, 32'hFFFF_FFFF, 32'h1,
      '{1'b1, 32'hFFFF_FFFF, 32'h1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
        32'hAAAA_AAAA}},
    '{1'b1, 16'd1040, 1'b0, 32'h0, 32'h0,
      '{1'b0, 32'h0, 32'h0, 32'h00C8_0000, 32'hFF38_0000, 32'h0064_0000, 32'h0}},
    '{1'b1, 16'd1041, 1'b0, 32'h0, 32'h0,
      '{1'b1, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h7FFF_0000,
        32'h8000_FFFF}},
    '{1'b1, 16'd1042, 1'b0, 32'h0, 32'h0, '{1'b0, 32'h0, 32'h0, PMIN, PMAX, 32'h0, 32'h0}},
    '{1'b1, 16'd65535, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PMAX, PMIN, 32'h1, 32'h1}},
    '{1'b1, 16'd65534, 1'b0, 32'h0, 32'h0,
      '{1'b0, PMIN, PMIN, 32'h0010_0000, 32'hFFF0_0000, PMIN, PMAX}},
    '{1'b1, 16'd32768, 1'b0, 32'h0, 32'h0,
      '{1'b1, 32'h0001_8000, 32'hFFFE_8000, 32'h0003_0000, 32'h0000_0001, PMAX, PMIN}},
    '{1'b1, 16'd32767, 1'b0, 32'h0, 32'h0,
      '{1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFD}},
    '{1'b1, 16'd1, 1'b0, 32'h0, 32'h0,
      '{1'b1, 32'h0100_0000, 32'hFF00_0000, 32'h7000_0000, 32'h9000_0000, 32'h0, 32'h0}},
    '{1'b1, 16'd1311, 1'b0, 32'h0, 32'h0,
      '{1'b0, PMAX, PMAX, 32'h0000_4000, 32'hFFFF_C000, 32'h0002_0000, 32'hFFFE_0000}},
    '{1'b0, 16'd0, 1'b0, 32'h0, 32'h0,
      '{1'b1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0}},
    '{1'b0, 16'd0, 1'b0, 32'h0, 32'h0,
      '{1'b0, 32'h0, 32'h0, 32'h0000_8000, 32'hFFFF_8000, 32'h3, 32'hFFFF_FFFD}}
  };

  quadratic_bezier_flattener_unit dut (
    .clk(clk),
    .rst(rst),
    .step_size_we(step_size_we),
    .step_size(step_size),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .new_path(new_path),
    .start_x(start_x),
    .start_y(start_y),
    .ctrl_x(ctrl_x),
    .ctrl_y(ctrl_y),
    .end_x(end_x),
    .end_y(end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .point_x(point_x),
    .point_y(point_y),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Round to nearest of (wa*p + wb*q + wc*r) / 2^32, halves up, saturated.
  function automatic logic [31:0] weighted_mean(input logic [32:0] wa, wb, wc,
                                                input logic [31:0] p, q, r);
    logic signed [97:0] acc;
    acc = $signed({65'd0, wa}) * $signed(p) + $signed({65'd0, wb}) * $signed(q)
        + $signed({65'd0, wc}) * $signed(r);
    acc = (acc + (98'sd1 <<< 31)) >>> 32;
    if (acc > 98'sd2147483647) return PMAX;
    if (acc < -98'sd2147483648) return PMIN;
    return acc[31:0];
  endfunction

  function automatic int flatten_curve(input seg_t s);
    logic [31:0] ax, ay;
    logic [15:0] h;
    logic [16:0] t;
    logic [32:0] u, wa, wb, wc;
    int n;
    ax = s.np ? s.sx : path_x;
    ay = s.np ? s.sy : path_y;
    h = (cur_step < qbf_pkg::STEP_MIN) ? qbf_pkg::STEP_MIN : cur_step;
    t = '0;
    n = 0;
    while (!t[16]) begin
      u = 33'd65536 - 33'(t);
      wa = u * u;
      wb = 33'd2 * 33'(t) * u;
      wc = 33'(t) * 33'(t);
      pending_pts.push_back('{weighted_mean(wa, wb, wc, ax, s.cx, s.ex),
                              weighted_mean(wa, wb, wc, ay, s.cy, s.ey), 1'b0});
      n++;
      t = t + 17'(h);
    end
    pending_pts.push_back('{s.ex, s.ey, 1'b1});
    path_x = s.ex;
    path_y = s.ey;
    return n + 1;
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 9))
      0: return PMAX;
      1: return PMIN;
      2: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic seg_t random_seg();
    seg_t s;
    s.np = ($urandom_range(0, 3) == 0);
    s.sx = random_coord();
    s.sy = random_coord();
    s.cx = random_coord();
    s.cy = random_coord();
    s.ex = random_coord();
    s.ey = random_coord();
    return s;
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 1040));
      1: return qbf_pkg::STEP_MIN;
      2: return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom_range(1041, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_seg(input seg_t s, input logic typed, input logic [31:0] fx, fy);
    int n;
    int k;
    point_t first;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    new_path <= s.np;
    start_x <= s.sx;
    start_y <= s.sy;
    ctrl_x <= s.cx;
    ctrl_y <= s.cy;
    end_x <= s.ex;
    end_y <= s.ey;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n = flatten_curve(s);
    if (typed) begin
      k = pending_pts.size() - n;
      first = pending_pts[k];
      first.px = fx;
      first.py = fy;
      pending_pts[k] = first;
    end
    @(negedge clk);
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pts.size() != 0) @(negedge clk);
  endtask

  task automatic write_step(input logic [15:0] v);
    drain_points();
    step_size_we <= 1'b1;
    step_size <= v;
    @(negedge clk);
    step_size_we <= 1'b0;
    cur_step = v;
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h last=%b", $time, point_x, point_y, last);
        errors++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (point_x !== exp_pt.px) begin
          $display("%0t: point_x expected %h got %h", $time, exp_pt.px, point_x);
          errors++;
        end
        if (point_y !== exp_pt.py) begin
          $display("%0t: point_y expected %h got %h", $time, exp_pt.py, point_y);
          errors++;
        end
        if (last !== exp_pt.lst) begin
          $display("%0t: last expected %b got %b", $time, exp_pt.lst, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("quadratic_bezier_flattener_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_step) write_step(dir_rows[i].step);
      send_seg(dir_rows[i].seg, dir_rows[i].typed, dir_rows[i].fx, dir_rows[i].fy);
    end

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = in_idle_by_phase[ph];
      out_stall_pct = out_stall_by_phase[ph];
      for (int k = 0; k < 3; k++) begin
        write_step(pick_step());
        for (int j = 0; j < SEGS_PER_STEP; j++) send_seg(random_seg(), 1'b0, '0, '0);
      end
    end

    drain_points();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("quadratic_bezier_flattener_unit test passed");
    end else begin
      $display("quadratic_bezier_flattener_unit test failed");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/qbf_pkg.sv
hw/rtl/qbf_lane.sv
hw/rtl/qbf_ctrl.sv
hw/rtl/quadratic_bezier_flattener_unit.sv
sim/quadratic_bezier_flattener_unit_tb.sv
